/* design/tlts_pkg.sv */
package tlts_pkg;

  localparam int unsigned MaxTasks = 16;
  localparam int unsigned SlotW    = $clog2(MaxTasks);
  localparam int unsigned FillW    = $clog2(MaxTasks + 1);

  localparam logic [1:0] KindSchedule = 2'd0;
  localparam logic [1:0] KindSleep    = 2'd1;
  localparam logic [1:0] KindWake     = 2'd2;
  localparam logic [1:0] KindAdmit    = 2'd3;

  typedef enum logic [1:0] {
    StUnused  = 2'd0,
    StReady   = 2'd1,
    StRunning = 2'd2,
    StBlocked = 2'd3
  } task_status_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  task_req;
    logic        priority_req;
    logic [31:0] sleep_duration;
    logic [31:0] now_time;
  } req_t;

  typedef struct packed {
    logic [3:0] running_task;
    logic       running_valid;
    logic [4:0] woken_count;
    logic       ignored;
  } rsp_t;

  typedef struct packed {
    logic             load;
    logic             pre;
    logic             pick;
    logic             scan;
    logic [SlotW-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       cur_valid;
  } sts_t;

endpackage

/* design/tlts_if.sv */
interface tlts_req_if import tlts_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tlts_rsp_if import tlts_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/tlts_ram.sv */
module tlts_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* design/tlts_ctrl.sv */
module tlts_ctrl import tlts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SPre  = 3'd1;
  localparam logic [2:0] SPick = 3'd2;
  localparam logic [2:0] SScan = 3'd3;
  localparam logic [2:0] SOut  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [SlotW-1:0] idx_q, idx_d;
  logic             last;

  assign last        = (idx_q == SlotW'(MaxTasks - 1));
  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cmd_o      = '0;
    cmd_o.idx  = idx_q;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = SPre;
          idx_d      = '0;
        end
      end
      SPre: begin
        cmd_o.pre = 1'b1;
        if (sts_i.kind == KindSchedule ||
            (sts_i.kind == KindSleep && sts_i.cur_valid)) begin
          state_d = SPick;
        end else if (sts_i.kind == KindWake) begin
          state_d = SScan;
        end else begin
          state_d = SOut;
        end
      end
      SPick: begin
        cmd_o.pick = 1'b1;
        state_d    = SScan;
      end
      SScan: begin
        cmd_o.scan = 1'b1;
        idx_d      = idx_q + 1'b1;
        if (last) begin
          state_d = SOut;
        end
      end
      SOut: begin
        if (out_ready_i) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end
endmodule

/* design/tlts_dp.sv */
module tlts_dp import tlts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  input  req_t       req_i,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  output rsp_t       rsp_o
);
  task_status_e     status_q [MaxTasks];
  logic             high_q   [MaxTasks];
  logic             mark_q   [MaxTasks];
  logic [SlotW-1:0] hfifo_q  [MaxTasks];
  logic [SlotW-1:0] lfifo_q  [MaxTasks];
  logic [SlotW-1:0] hhead_q, lhead_q, cur_q;
  logic [FillW-1:0] hfill_q, lfill_q;
  logic             cur_valid_q, ignored_q;
  logic [3:0]       streak_q, limit_q;
  logic [4:0]       woken_q;
  req_t             req_q;

  logic [31:0]      start_rd, len_rd;
  logic             sleep_we;
  logic [SlotW-1:0] ram_raddr;
  logic [31:0]      elapsed;

  assign sleep_we  = cmd_i.pre && req_q.kind == KindSleep && cur_valid_q;
  assign ram_raddr = cmd_i.load ? '0 : ((cmd_i.scan || cmd_i.pick) ?
                     ((cmd_i.scan) ? cmd_i.idx + 1'b1 : '0) : '0);
  assign elapsed   = req_q.now_time - start_rd;

  tlts_ram #(.Width(32), .Depth(MaxTasks)) u_start (
    .clk_i, .we_i(sleep_we), .waddr_i(cur_q), .wdata_i(req_q.now_time),
    .raddr_i(ram_raddr), .rdata_o(start_rd));

  tlts_ram #(.Width(32), .Depth(MaxTasks)) u_len (
    .clk_i, .we_i(sleep_we), .waddr_i(cur_q), .wdata_i(req_q.sleep_duration),
    .raddr_i(ram_raddr), .rdata_o(len_rd));

  assign sts_o.kind      = req_q.kind;
  assign sts_o.cur_valid = cur_valid_q;

  assign rsp_o.running_task  = cur_valid_q ? cur_q : '0;
  assign rsp_o.running_valid = cur_valid_q;
  assign rsp_o.woken_count   = woken_q;
  assign rsp_o.ignored       = ignored_q;

  logic             take_high, take_low;
  logic [SlotW-1:0] pick;
  logic [SlotW-1:0] i;

  assign take_high = hfill_q != '0 && (streak_q < limit_q || lfill_q == '0);
  assign take_low  = !take_high && lfill_q != '0;
  assign pick      = take_high ? hfifo_q[hhead_q] : lfifo_q[lhead_q];
  assign i         = cmd_i.idx;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.scan && req_q.kind != KindWake && status_q[i] == StReady && !mark_q[i]) begin
      if (high_q[i]) begin
        if (hfill_q != FillW'(MaxTasks)) begin
          hfifo_q[hhead_q + hfill_q[SlotW-1:0]] <= i;
        end
      end else if (lfill_q != FillW'(MaxTasks)) begin
        lfifo_q[lhead_q + lfill_q[SlotW-1:0]] <= i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MaxTasks; k++) begin
        status_q[k] <= StUnused;
        high_q[k]   <= 1'b0;
        mark_q[k]   <= 1'b0;
      end
      hhead_q     <= '0;
      lhead_q     <= '0;
      hfill_q     <= '0;
      lfill_q     <= '0;
      cur_q       <= '0;
      cur_valid_q <= 1'b0;
      streak_q    <= '0;
      limit_q     <= 4'd3;
      woken_q     <= '0;
      ignored_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        woken_q   <= '0;
        ignored_q <= 1'b0;
      end
      if (cmd_i.pre) begin
        case (req_q.kind)
          KindSleep: begin
            if (cur_valid_q) begin
              status_q[cur_q] <= StBlocked;
              cur_valid_q     <= 1'b0;
            end else begin
              ignored_q <= 1'b1;
            end
          end
          KindAdmit: begin
            if (status_q[req_q.task_req] != StReady) begin
              woken_q <= 5'd1;
            end
            if (cur_valid_q && cur_q == req_q.task_req) begin
              cur_valid_q <= 1'b0;
            end
            status_q[req_q.task_req] <= StReady;
            high_q[req_q.task_req]   <= req_q.priority_req;
          end
          default: ;
        endcase
      end
      if (cmd_i.pick && (take_high || take_low)) begin
        if (take_high) begin
          hhead_q <= hhead_q + 1'b1;
          hfill_q <= hfill_q - 1'b1;
          if (streak_q != 4'hF) begin
            streak_q <= streak_q + 1'b1;
          end
        end else begin
          lhead_q  <= lhead_q + 1'b1;
          lfill_q  <= lfill_q - 1'b1;
          streak_q <= '0;
        end
        if (cur_valid_q && status_q[cur_q] == StRunning) begin
          status_q[cur_q] <= StReady;
        end
        mark_q[pick]   <= 1'b0;
        status_q[pick] <= StRunning;
        cur_q          <= pick;
        cur_valid_q    <= 1'b1;
      end
      if (cmd_i.scan) begin
        if (req_q.kind == KindWake) begin
          if (status_q[i] == StBlocked && elapsed >= len_rd) begin
            status_q[i] <= StReady;
            woken_q     <= woken_q + 1'b1;
          end
        end else if (status_q[i] == StReady && !mark_q[i]) begin
          mark_q[i] <= 1'b1;
          if (high_q[i]) begin
            if (hfill_q != FillW'(MaxTasks)) begin
              hfill_q <= hfill_q + 1'b1;
            end
          end else if (lfill_q != FillW'(MaxTasks)) begin
            lfill_q <= lfill_q + 1'b1;
          end
        end
      end
    end
  end
endmodule

/* design/two_level_task_scheduler.sv */
// channel   direction  fields
// in_req    sink       kind, task_req, priority_req, sleep_duration, now_time
// out_rsp   source     running_task, running_valid, woken_count, ignored
// cfg       write      high_burst_limit (cfg_we_i, cfg_wdata_i)
//
// Schedule, and sleep with a task running, pass pre, pick and the 16-slot scan;
// wake passes pre and scan; admit, and sleep with no task running, pre only.
// One transaction is in flight at a time; in_req.ready is low until the result
// is taken. Reset is asynchronous and clears all task state at once.
module two_level_task_scheduler import tlts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  tlts_req_if.sink   in_req,
  tlts_rsp_if.source out_rsp
);
  cmd_t cmd;
  sts_t sts;

  tlts_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_req.valid), .in_ready_o(in_req.ready),
    .out_valid_o(out_rsp.valid), .out_ready_i(out_rsp.ready),
    .sts_i(sts), .cmd_o(cmd));

  tlts_dp u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .req_i(in_req.data), .cmd_i(cmd), .sts_o(sts), .rsp_o(out_rsp.data));
endmodule

/* design/tlts_checker.sv */
module tlts_assert import tlts_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input rsp_t out_data
);
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("input open while result pending");
  a_task_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_data.running_valid |-> out_data.running_task == '0)
    else $error("running_task not zero");
  a_woken_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data.woken_count <= 5'd16) else $error("woken_count range");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped");
  a_accept_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("back to back accept");
endmodule

bind two_level_task_scheduler tlts_assert u_checker (
  .clk_i, .rst_ni,
  .in_valid(in_req.valid), .in_ready(in_req.ready),
  .out_valid(out_rsp.valid), .out_ready(out_rsp.ready), .out_data(out_rsp.data));
